// ----- rtl/mpr_pkg.sv -----
// Package for the MII PHY management register block.
// Holds the request and response types, register addresses, codes and bit constants.
// No dependencies.
package mpr_pkg;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  reg_addr;
      logic [15:0] write_data;
      logic        link_is_down;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq;
      logic [1:0]  access_status;
   } rsp_type;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_LINK  = 2'd2;

   localparam logic [1:0] ACC_OK       = 2'd0;
   localparam logic [1:0] ACC_UNIMPL   = 2'd1;
   localparam logic [1:0] ACC_BAD_ADDR = 2'd2;

   localparam logic [4:0] REG_CONTROL    = 5'd0;
   localparam logic [4:0] REG_STATUS     = 5'd1;
   localparam logic [4:0] REG_ID_HIGH    = 5'd2;
   localparam logic [4:0] REG_ID_LOW     = 5'd3;
   localparam logic [4:0] REG_ADVERTISE  = 5'd4;
   localparam logic [4:0] REG_PARTNER    = 5'd5;
   localparam logic [4:0] REG_EXPANSION  = 5'd6;
   localparam logic [4:0] REG_UNIMPL_A   = 5'd17;
   localparam logic [4:0] REG_UNIMPL_B   = 5'd18;
   localparam logic [4:0] REG_UNIMPL_C   = 5'd27;
   localparam logic [4:0] REG_INT_SOURCE = 5'd29;
   localparam logic [4:0] REG_INT_MASK   = 5'd30;
   localparam logic [4:0] REG_UNIMPL_D   = 5'd31;

   localparam logic [15:0] PHY_ID_HIGH      = 16'd7;
   localparam logic [15:0] PHY_ID_LOW       = 16'd49347;
   localparam logic [15:0] CTRL_RESET_BIT   = 16'h8000;
   localparam logic [15:0] CTRL_AUTOEN_BIT  = 16'h1000;
   localparam logic [15:0] CTRL_WRITE_MASK  = 16'h7980;
   localparam logic [15:0] CTRL_AT_RESET    = 16'h3000;
   localparam logic [15:0] STAT_AT_RESET    = 16'h7809;
   localparam logic [15:0] STAT_AN_COMPLETE = 16'h0020;
   localparam logic [15:0] STAT_LINK_UP     = 16'h0004;
   localparam logic [15:0] ADV_WRITE_MASK   = 16'h2D7F;
   localparam logic [15:0] ADV_100TX        = 16'h0080;
   localparam logic [15:0] ADV_AT_RESET     = 16'h01E1;
   localparam logic [15:0] PARTNER_ABILITY  = 16'h0FE1;
   localparam logic [15:0] EXPANSION_VALUE  = 16'h0001;
   localparam logic [7:0]  INT_ENERGY_ON    = 8'h80;
   localparam logic [7:0]  INT_AN_COMPLETE  = 8'h40;
   localparam logic [7:0]  INT_LINK_DOWN    = 8'h10;

endpackage

// ----- rtl/mpr_core.sv -----
// Register file and access logic of the MII PHY management register block.
// Executes one registered request per step and forms its response; uses mpr_pkg.
module mpr_core
   import mpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type rsp
);

   logic [15:0] ctrl_ff, ctrl_in;
   logic [15:0] stat_ff, stat_in;
   logic [15:0] adv_ff, adv_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  en_ff, en_in;
   logic        down_ff, down_in;
   logic [15:0] rdata;
   logic [1:0]  status;
   logic        unimpl;

   assign unimpl = (req.reg_addr == REG_UNIMPL_A) || (req.reg_addr == REG_UNIMPL_B) ||
                   (req.reg_addr == REG_UNIMPL_C) || (req.reg_addr == REG_UNIMPL_D);

   always_comb begin
      ctrl_in = ctrl_ff;
      stat_in = stat_ff;
      adv_in  = adv_ff;
      src_in  = src_ff;
      en_in   = en_ff;
      down_in = down_ff;
      rdata   = '0;
      status  = ACC_OK;
      unique case (req.kind)
         KIND_READ: begin
            unique case (req.reg_addr)
               REG_CONTROL:    rdata = ctrl_ff;
               REG_STATUS:     rdata = stat_ff;
               REG_ID_HIGH:    rdata = PHY_ID_HIGH;
               REG_ID_LOW:     rdata = PHY_ID_LOW;
               REG_ADVERTISE:  rdata = adv_ff;
               REG_PARTNER:    rdata = PARTNER_ABILITY;
               REG_EXPANSION:  rdata = EXPANSION_VALUE;
               REG_INT_SOURCE: begin
                  rdata  = {8'h00, src_ff};
                  src_in = '0;
               end
               REG_INT_MASK:   rdata = {8'h00, en_ff};
               default:        status = unimpl ? ACC_UNIMPL : ACC_BAD_ADDR;
            endcase
         end
         KIND_WRITE: begin
            unique case (req.reg_addr)
               REG_CONTROL: begin
                  if ((req.write_data & CTRL_RESET_BIT) != '0) begin
                     // A soft reset restores defaults, then replays the current link state.
                     ctrl_in = CTRL_AT_RESET;
                     adv_in  = ADV_AT_RESET;
                     en_in   = '0;
                     if (down_ff) begin
                        stat_in = STAT_AT_RESET & ~(STAT_AN_COMPLETE | STAT_LINK_UP);
                        src_in  = INT_LINK_DOWN;
                     end else begin
                        stat_in = STAT_AT_RESET | STAT_AN_COMPLETE | STAT_LINK_UP;
                        src_in  = INT_ENERGY_ON | INT_AN_COMPLETE;
                     end
                  end else begin
                     ctrl_in = req.write_data & CTRL_WRITE_MASK;
                     if ((req.write_data & CTRL_AUTOEN_BIT) != '0) begin
                        stat_in = stat_ff | STAT_AN_COMPLETE;
                     end
                  end
               end
               REG_ADVERTISE: adv_in = (req.write_data & ADV_WRITE_MASK) | ADV_100TX;
               REG_INT_MASK:  en_in  = req.write_data[7:0];
               default:       status = unimpl ? ACC_UNIMPL : ACC_BAD_ADDR;
            endcase
         end
         KIND_LINK: begin
            down_in = req.link_is_down;
            if (req.link_is_down) begin
               stat_in = stat_ff & ~(STAT_AN_COMPLETE | STAT_LINK_UP);
               src_in  = src_ff | INT_LINK_DOWN;
            end else begin
               stat_in = stat_ff | STAT_AN_COMPLETE | STAT_LINK_UP;
               src_in  = src_ff | INT_ENERGY_ON | INT_AN_COMPLETE;
            end
         end
         default: ;
      endcase
   end

   assign rsp.read_data     = rdata;
   assign rsp.irq           = |(src_in & en_in);
   assign rsp.access_status = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= CTRL_AT_RESET;
         stat_ff <= STAT_AT_RESET | STAT_AN_COMPLETE | STAT_LINK_UP;
         adv_ff  <= ADV_AT_RESET;
         src_ff  <= INT_ENERGY_ON | INT_AN_COMPLETE;
         en_ff   <= '0;
         down_ff <= 1'b0;
      end else if (step) begin
         ctrl_ff <= ctrl_in;
         stat_ff <= stat_in;
         adv_ff  <= adv_in;
         src_ff  <= src_in;
         en_ff   <= en_in;
         down_ff <= down_in;
      end
   end

endmodule

// ----- rtl/mii_phy_register_block.sv -----
// Top level of the MII PHY management register block: request register, core, response register.
// Depends on mpr_pkg and mpr_core.
//
// Each request is a register read, a register write or a link-change event, and gives exactly
// one response. A request is captured in an input register and executed against the register
// file once the response register is free to take its result; that response is then registered
// and raises rsp_valid. One request is accepted every cycle while the response
// side keeps up; the response register decouples the two sides, and req_stall rises only when
// both the input and response registers hold requests the response side has not taken.
module mii_phy_register_block
   import mpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type core_rsp;
   logic    out_free;
   logic    step;
   logic    load;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign step         = req_valid_ff && out_free;
   assign load         = !req_valid_ff || out_free;
   assign req_stall    = !load;
   assign req_valid_in = load ? req_valid : req_valid_ff;
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   mpr_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load && req_valid) begin
         req_ff <= req_payload;
      end
      if (step) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid_ff))
      else $error("response appeared without a pending request");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !out_free) |=> (req_valid_ff && $stable(req_ff)))
      else $error("pending request lost while the response side was stalled");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.access_status != ACC_OK) |-> (rsp_payload.read_data == '0))
      else $error("failed access returned non-zero read data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.access_status == ACC_OK ||
                     rsp_payload.access_status == ACC_UNIMPL ||
                     rsp_payload.access_status == ACC_BAD_ADDR))
      else $error("reserved access status code");

endmodule
